### src/baro_pressure_compensation_unit_assert.svh
// assertion macros for the pressure compensation unit
// the asserting module must have clk and rst (synchronous, active high) in scope
`ifndef BARO_PRESSURE_COMPENSATION_UNIT_ASSERT_SVH
`define BARO_PRESSURE_COMPENSATION_UNIT_ASSERT_SVH

// same-cycle implication
`define BPC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BPC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/bpc_pkg.sv
// shared widths, register indexes, constants and stage payload types
// for the pressure compensation unit; no dependencies
`default_nettype none

package bpc_pkg;

  localparam int RAW_W      = 24;
  localparam int COEF_W     = 16;
  localparam int NUM_COEFS  = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int PRESS_W    = 32;
  localparam int TEMP_OUT_W = 18;

  // internal widths, sized from the value ranges
  localparam int DT_W    = 25;   // temperature delta
  localparam int MP_W    = 42;   // coefficient times delta
  localparam int TEMP_W  = 19;   // full temperature
  localparam int SQ_W    = 38;   // squared temperature terms
  localparam int OS_W    = 40;   // offset and sensitivity
  localparam int SPLIT_W = 20;   // low slice of sensitivity for the split product
  localparam int PP_LO_W = RAW_W + SPLIT_W;
  localparam int PP_HI_W = RAW_W + 1 + OS_W - SPLIT_W;
  localparam int PROD_W  = 64;
  localparam int Y_W     = 48;

  // fixed scalings of the scheme
  localparam int SHIFT_REF    = 8;
  localparam int SHIFT_OFF_C  = 16;
  localparam int SHIFT_SENS_C = 15;
  localparam int SHIFT_OFF_T  = 7;
  localparam int SHIFT_SENS_T = 8;
  localparam int SHIFT_TEMP   = 23;
  localparam int SHIFT_PROD   = 21;
  localparam int SHIFT_PRESS  = 15;
  localparam int TEMP_MID     = 2000;
  localparam int TEMP_LOW     = 1500;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PRESSURE_SENS     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRESSURE_OFFSET   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SENS_TEMP_COEFF   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_TEMP_COEFF = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_REF_TEMPERATURE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_SENSITIVITY  = 3'd5;

  typedef struct packed {
    logic [COEF_W-1:0] pressure_sens;
    logic [COEF_W-1:0] pressure_offset;
    logic [COEF_W-1:0] sens_temp_coeff;
    logic [COEF_W-1:0] offset_temp_coeff;
    logic [COEF_W-1:0] ref_temperature;
    logic [COEF_W-1:0] temp_sensitivity;
  } coef_t;

  // first-order terms, handed to the correction stages
  typedef struct packed {
    logic [RAW_W-1:0]         d1;
    logic signed [OS_W-1:0]   offs;
    logic signed [OS_W-1:0]   sens;
    logic signed [TEMP_W-1:0] temp;
    logic signed [TEMP_W-1:0] tm;    // temp - 2000
    logic signed [TEMP_W-1:0] tl;    // temp + 1500
    logic                     lt_mid;
    logic                     lt_low;
  } tc_t;

  // corrected terms, handed to the pressure product
  typedef struct packed {
    logic [RAW_W-1:0]         d1;
    logic signed [OS_W-1:0]   offs;
    logic signed [OS_W-1:0]   sens;
    logic signed [TEMP_W-1:0] temp;
  } cs_t;

endpackage

`default_nettype wire

### src/bpc_in_if.sv
// input channel: one raw pressure and temperature pair per item
// depends on bpc_pkg
`default_nettype none

interface bpc_in_if;
  logic                        valid;
  logic                        ready;
  logic [bpc_pkg::RAW_W-1:0]   raw_pressure;
  logic [bpc_pkg::RAW_W-1:0]   raw_temperature;

  modport source (output valid, output raw_pressure, output raw_temperature, input ready);
  modport sink   (input valid, input raw_pressure, input raw_temperature, output ready);
endinterface

`default_nettype wire

### src/bpc_out_if.sv
// result channel: compensated pressure and temperature per item
// depends on bpc_pkg
`default_nettype none

interface bpc_out_if;
  logic                                  valid;
  logic                                  ready;
  logic [bpc_pkg::PRESS_W-1:0]           pressure_out;
  logic signed [bpc_pkg::TEMP_OUT_W-1:0] temperature_out;

  modport source (output valid, output pressure_out, output temperature_out, input ready);
  modport sink   (input valid, input pressure_out, input temperature_out, output ready);
endinterface

`default_nettype wire

### src/bpc_cfg_if.sv
// configuration write channel: register index and write data
// depends on bpc_pkg
`default_nettype none

interface bpc_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [bpc_pkg::CFG_IDX_W-1:0]   index;
  logic [bpc_pkg::COEF_W-1:0]      data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### src/baro_pressure_compensation_unit.sv
// Barometric pressure compensation, second-order scheme. One raw pressure and
// temperature pair enters per clock while the pipeline is not stalled, and one
// compensated result leaves per pair. Each pair passes through eight register
// stages: delta, coefficient products, first-order sums, squares, corrections,
// split pressure product, recombination and the output register. Every stage
// stalls on its own, so bubbles are squeezed out and input is still taken while
// a result waits. The six calibration words are written through the
// configuration channel, which is always ready; writes to indexes past the last
// register are dropped. Pressure is in 0.01 mbar (low 32 bits), temperature in
// 0.01 degC (low 18 bits, two's complement).
// depends on bpc_pkg, the channel interfaces and the three stage modules
`default_nettype none

`include "baro_pressure_compensation_unit_assert.svh"

module baro_pressure_compensation_unit (
  input  wire logic  clk,
  input  wire logic  rst,
  bpc_cfg_if.sink    cfg,
  bpc_in_if.sink     raw_in,
  bpc_out_if.source  result_out
);
  import bpc_pkg::*;

  coef_t coef;

  logic tc_valid, tc_ready;
  tc_t  tc;
  logic cs_valid, cs_ready;
  cs_t  cs;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_PRESSURE_SENS:     coef.pressure_sens     <= cfg.data;
        REG_PRESSURE_OFFSET:   coef.pressure_offset   <= cfg.data;
        REG_SENS_TEMP_COEFF:   coef.sens_temp_coeff   <= cfg.data;
        REG_OFFSET_TEMP_COEFF: coef.offset_temp_coeff <= cfg.data;
        REG_REF_TEMPERATURE:   coef.ref_temperature   <= cfg.data;
        REG_TEMP_SENSITIVITY:  coef.temp_sensitivity  <= cfg.data;
        default: ;
      endcase
    end
  end

  bpc_tcomp u_tcomp (
    .clk       (clk),
    .rst       (rst),
    .coef      (coef),
    .in_valid  (raw_in.valid),
    .in_ready  (raw_in.ready),
    .d1        (raw_in.raw_pressure),
    .d2        (raw_in.raw_temperature),
    .out_valid (tc_valid),
    .out_ready (tc_ready),
    .out_data  (tc)
  );

  bpc_corr u_corr (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (tc_valid),
    .in_ready  (tc_ready),
    .in_data   (tc),
    .out_valid (cs_valid),
    .out_ready (cs_ready),
    .out_data  (cs)
  );

  bpc_pmul u_pmul (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (cs_valid),
    .in_ready    (cs_ready),
    .in_data     (cs),
    .out_valid   (result_out.valid),
    .out_ready   (result_out.ready),
    .pressure    (result_out.pressure_out),
    .temperature (result_out.temperature_out)
  );

  // items held between the stage groups must not change while stalled
  `BPC_ASSERT_NEXT(a_tc_hold, tc_valid && !tc_ready, tc_valid && $stable(tc), "tc item lost")
  `BPC_ASSERT_NEXT(a_cs_hold, cs_valid && !cs_ready, cs_valid && $stable(cs), "cs item lost")
  // the low-temperature term only ever applies on top of the mid one
  `BPC_ASSERT_NOW(a_low_in_mid, tc_valid && tc.lt_low, tc.lt_mid, "low without mid correction")
  // writes past the register file leave the calibration untouched
  `BPC_ASSERT_NEXT(a_cfg_drop, cfg.valid && cfg.index > REG_TEMP_SENSITIVITY, $stable(coef),
                   "out-of-range write changed calibration")

endmodule

`default_nettype wire

### src/bpc_tcomp.sv
// first-order stages: temperature delta, coefficient products, offset,
// sensitivity and temperature; depends on bpc_pkg
`default_nettype none

module bpc_tcomp (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire bpc_pkg::coef_t              coef,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [bpc_pkg::RAW_W-1:0]   d1,
  input  wire logic [bpc_pkg::RAW_W-1:0]   d2,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output bpc_pkg::tc_t                     out_data
);
  import bpc_pkg::*;

  logic v1, v2, v3;
  logic en1, en2, en3;

  logic [RAW_W-1:0]         d1_1, d1_2;
  logic signed [DT_W-1:0]   dt_1, dt_next;
  logic signed [MP_W-1:0]   p_sens, p_offs, p_temp;
  logic signed [MP_W-1:0]   p_sens_next, p_offs_next, p_temp_next;
  tc_t                      tc, tc_next;

  assign en3      = !v3 || out_ready;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_ready = en1;

  // stage 1: delta from reference temperature
  assign dt_next = $signed({1'b0, d2}) -
                   $signed({1'b0, coef.ref_temperature, {SHIFT_REF{1'b0}}});

  // stage 2: three coefficient products
  always_comb begin
    p_sens_next = dt_1 * $signed({1'b0, coef.sens_temp_coeff});
    p_offs_next = dt_1 * $signed({1'b0, coef.offset_temp_coeff});
    p_temp_next = dt_1 * $signed({1'b0, coef.temp_sensitivity});
  end

  // stage 3: scaled sums
  always_comb begin
    tc_next.d1   = d1_2;
    tc_next.offs = OS_W'($signed({1'b0, coef.pressure_offset, {SHIFT_OFF_C{1'b0}}}))
                 + OS_W'(p_offs >>> SHIFT_OFF_T);
    tc_next.sens = OS_W'($signed({1'b0, coef.pressure_sens, {SHIFT_SENS_C{1'b0}}}))
                 + OS_W'(p_sens >>> SHIFT_SENS_T);
    tc_next.tm   = TEMP_W'(p_temp >>> SHIFT_TEMP);
    tc_next.temp = TEMP_W'(tc_next.tm + TEMP_MID);
    tc_next.tl   = TEMP_W'(tc_next.tm + (TEMP_MID + TEMP_LOW));
    tc_next.lt_mid = tc_next.tm[TEMP_W-1];
    tc_next.lt_low = tc_next.tl[TEMP_W-1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      d1_1 <= d1;
      dt_1 <= dt_next;
    end
    if (en2) begin
      d1_2   <= d1_1;
      p_sens <= p_sens_next;
      p_offs <= p_offs_next;
      p_temp <= p_temp_next;
    end
    if (en3) begin
      tc <= tc_next;
    end
  end

  assign out_valid = v3;
  assign out_data  = tc;

endmodule

`default_nettype wire

### src/bpc_corr.sv
// second-order correction stages: squared temperature terms and their
// subtraction from offset and sensitivity; depends on bpc_pkg
`default_nettype none

module bpc_corr (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire bpc_pkg::tc_t in_data,
  output logic              out_valid,
  input  wire logic         out_ready,
  output bpc_pkg::cs_t      out_data
);
  import bpc_pkg::*;

  logic v1, v2;
  logic en1, en2;

  logic signed [SQ_W-1:0]   sq_mid, sq_low, sq_mid_next, sq_low_next;
  tc_t                      s1;
  logic signed [OS_W-1:0]   mid5, low1, low7, low11;
  logic signed [OS_W-1:0]   offs_mid, offs_low, sens_mid, sens_low;
  cs_t                      cs, cs_next;

  assign en2      = !v2 || out_ready;
  assign en1      = !v1 || en2;
  assign in_ready = en1;

  // stage 1: squares
  always_comb begin
    sq_mid_next = in_data.tm * in_data.tm;
    sq_low_next = in_data.tl * in_data.tl;
  end

  // stage 2: small constant multiples by shift and add, then subtract
  always_comb begin
    mid5  = (OS_W'(sq_mid) <<< 2) + OS_W'(sq_mid);
    low1  = OS_W'(sq_low);
    low7  = (low1 <<< 3) - low1;
    low11 = (low1 <<< 3) + (low1 <<< 1) + low1;
    offs_mid = s1.lt_mid ? (mid5 >>> 1) : '0;
    sens_mid = s1.lt_mid ? (mid5 >>> 2) : '0;
    offs_low = s1.lt_low ? low7 : '0;
    sens_low = s1.lt_low ? (low11 >>> 1) : '0;
    cs_next.d1   = s1.d1;
    cs_next.temp = s1.temp;
    cs_next.offs = s1.offs - offs_mid - offs_low;
    cs_next.sens = s1.sens - sens_mid - sens_low;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1     <= in_data;
      sq_mid <= sq_mid_next;
      sq_low <= sq_low_next;
    end
    if (en2) begin
      cs <= cs_next;
    end
  end

  assign out_valid = v2;
  assign out_data  = cs;

endmodule

`default_nettype wire

### src/bpc_pmul.sv
// pressure stages: raw pressure times sensitivity as two partial products,
// their sum, the offset subtraction and the output register; depends on bpc_pkg
`default_nettype none

module bpc_pmul (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire bpc_pkg::cs_t                         in_data,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic [bpc_pkg::PRESS_W-1:0]               pressure,
  output logic signed [bpc_pkg::TEMP_OUT_W-1:0]     temperature
);
  import bpc_pkg::*;

  logic v1, v2, v3;
  logic en1, en2, en3;

  logic [PP_LO_W-1:0]         pp_lo, pp_lo_next;
  logic signed [PP_HI_W-1:0]  pp_hi, pp_hi_next;
  logic signed [OS_W-1:0]     offs_1, offs_2;
  logic signed [TEMP_W-1:0]   temp_1, temp_2;
  logic signed [PROD_W-1:0]   prod, prod_next;
  logic signed [Y_W-1:0]      y_next;

  assign en3      = !v3 || out_ready;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_ready = en1;

  // stage 1: unsigned low slice and signed high slice of sensitivity
  always_comb begin
    pp_lo_next = in_data.d1 * in_data.sens[SPLIT_W-1:0];
    pp_hi_next = $signed({1'b0, in_data.d1}) * $signed(in_data.sens[OS_W-1:SPLIT_W]);
  end

  // stage 2: recombine
  assign prod_next = (PROD_W'(pp_hi) <<< SPLIT_W) + PROD_W'({1'b0, pp_lo});

  // stage 3: scale, subtract offset, keep low bits after the final shift
  assign y_next = Y_W'(prod >>> SHIFT_PROD) - Y_W'(offs_2);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      pp_lo  <= pp_lo_next;
      pp_hi  <= pp_hi_next;
      offs_1 <= in_data.offs;
      temp_1 <= in_data.temp;
    end
    if (en2) begin
      prod   <= prod_next;
      offs_2 <= offs_1;
      temp_2 <= temp_1;
    end
    if (en3) begin
      pressure    <= y_next[SHIFT_PRESS +: PRESS_W];
      temperature <= temp_2[TEMP_OUT_W-1:0];
    end
  end

  assign out_valid = v3;

endmodule

`default_nettype wire

### tb/baro_pressure_compensation_unit_test.sv
`timescale 1ns / 1ps
// self-checking bench for the barometric pressure compensation unit: readings go in through
// the raw channel, a local second-order compensation predicts every result
// depends on bpc_pkg, bpc_in_if, bpc_out_if, bpc_cfg_if and baro_pressure_compensation_unit

module baro_pressure_compensation_unit_test;
  import bpc_pkg::*;

  localparam logic [RAW_W-1:0] RAW_MAX = {RAW_W{1'b1}};
  localparam int MAX_GAP = 20;

  typedef struct packed {
    logic [PRESS_W-1:0]           pressure;
    logic signed [TEMP_OUT_W-1:0] temperature;
  } compensated_t;

  logic clk;
  logic rst;

  bpc_cfg_if cfg ();
  bpc_in_if  raw_in ();
  bpc_out_if result_out ();

  baro_pressure_compensation_unit i_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .raw_in     (raw_in),
    .result_out (result_out)
  );

  logic [COEF_W-1:0] cal_words [NUM_COEFS];
  compensated_t      expected_q [$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_cycles   = 0;
  int error_count   = 0;
  int readings_sent = 0;
  int results_seen  = 0;
  int cal_sets      = 0;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // second-order compensation, full width, floor shifts
  function automatic compensated_t compensate(input logic [RAW_W-1:0] d1_raw,
                                              input logic [RAW_W-1:0] d2_raw);
    longint d1, d2, c1, c2, c3, c4, c5, c6;
    longint dt, offs, sens, temp, corr, press;
    compensated_t r;
    d1 = longint'(d1_raw);
    d2 = longint'(d2_raw);
    c1 = longint'(cal_words[REG_PRESSURE_SENS]);
    c2 = longint'(cal_words[REG_PRESSURE_OFFSET]);
    c3 = longint'(cal_words[REG_SENS_TEMP_COEFF]);
    c4 = longint'(cal_words[REG_OFFSET_TEMP_COEFF]);
    c5 = longint'(cal_words[REG_REF_TEMPERATURE]);
    c6 = longint'(cal_words[REG_TEMP_SENSITIVITY]);
    dt   = d2 - c5 * 256;
    offs = c2 * 65536 + ((c4 * dt) >>> 7);
    sens = c1 * 32768 + ((c3 * dt) >>> 8);
    temp = TEMP_MID + ((dt * c6) >>> 23);
    if (temp < TEMP_MID) begin
      corr = temp - TEMP_MID;
      corr = 5 * corr * corr;
      offs = offs - (corr >>> 1);
      sens = sens - (corr >>> 2);
      if (temp < -TEMP_LOW) begin
        corr = temp + TEMP_LOW;
        corr = corr * corr;
        offs = offs - 7 * corr;
        sens = sens - ((11 * corr) >>> 1);
      end
    end
    press = (((d1 * sens) >>> 21) - offs) >>> 15;
    r.pressure    = press[PRESS_W-1:0];
    r.temperature = temp[TEMP_OUT_W-1:0];
    return r;
  endfunction

  function automatic logic [RAW_W-1:0] clamp_raw(input longint v);
    longint c;
    c = v;
    if (c < 0) c = 0;
    if (c > longint'(RAW_MAX)) c = longint'(RAW_MAX);
    return c[RAW_W-1:0];
  endfunction

  // raw temperature that lands on a given temperature under the current calibration
  function automatic logic [RAW_W-1:0] raw_temp_for(input int target);
    longint k, c6, dt;
    k  = longint'(target) - TEMP_MID;
    c6 = longint'(cal_words[REG_TEMP_SENSITIVITY]);
    dt = 0;
    if (c6 != 0) begin
      if (k >= 0) dt = ((k <<< 23) + c6 - 1) / c6;
      else dt = -(((-k) <<< 23) / c6);
    end
    return clamp_raw(longint'(cal_words[REG_REF_TEMPERATURE]) * 256 + dt);
  endfunction

  // result side: random stalls, plus a counted hold-off on request
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      result_out.ready = 1'b0;
      hold_cycles--;
    end else begin
      result_out.ready = ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    compensated_t want;
    if (!rst && result_out.valid && result_out.ready) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result, pressure %h temperature %h", $time,
                 result_out.pressure_out, result_out.temperature_out);
        error_count++;
      end else begin
        want = expected_q.pop_front();
        if (result_out.pressure_out !== want.pressure) begin
          $display("%0t: pressure_out expected %h actual %h", $time,
                   want.pressure, result_out.pressure_out);
          error_count++;
        end
        if (result_out.temperature_out !== want.temperature) begin
          $display("%0t: temperature_out expected %h actual %h", $time,
                   want.temperature, result_out.temperature_out);
          error_count++;
        end
      end
    end
  end

  task automatic send_reading(input logic [RAW_W-1:0] d1, input logic [RAW_W-1:0] d2);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(0, 99) < send_idle_pct) gap++;
    @(negedge clk);
    if (gap > 0) begin
      raw_in.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    raw_in.valid           = 1'b1;
    raw_in.raw_pressure    = d1;
    raw_in.raw_temperature = d2;
    do @(posedge clk); while (!raw_in.ready);
    expected_q.push_back(compensate(d1, d2));
    readings_sent++;
  endtask

  // lower valid and wait until every outstanding item has come back
  task automatic drain();
    @(negedge clk);
    raw_in.valid = 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_coef(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] value);
    @(negedge clk);
    cfg.valid = 1'b1;
    cfg.index = idx;
    cfg.data  = value;
    do @(posedge clk); while (!cfg.ready);
    if (idx < NUM_COEFS) cal_words[idx] = value;
    @(negedge clk);
    cfg.valid = 1'b0;
  endtask

  task automatic load_calibration(input logic [COEF_W-1:0] c1, c2, c3, c4, c5, c6);
    drain();
    write_coef(REG_PRESSURE_SENS, c1);
    write_coef(REG_PRESSURE_OFFSET, c2);
    write_coef(REG_SENS_TEMP_COEFF, c3);
    write_coef(REG_OFFSET_TEMP_COEFF, c4);
    write_coef(REG_REF_TEMPERATURE, c5);
    write_coef(REG_TEMP_SENSITIVITY, c6);
    cal_sets++;
  endtask

  function automatic logic [COEF_W-1:0] random_word();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return '0;
    if (sel == 1) return '1;
    return COEF_W'($urandom_range(0, 65535));
  endfunction

  task automatic load_random_calibration();
    int sel;
    sel = $urandom_range(0, 7);
    if (sel == 0) load_calibration('0, '0, '0, '0, '0, '0);
    else if (sel == 1) load_calibration('1, '1, '1, '1, '1, '1);
    else load_calibration(random_word(), random_word(), random_word(),
                          random_word(), random_word(), random_word());
  endtask

  task automatic send_random_reading();
    logic [RAW_W-1:0] d1, d2;
    int sel;
    d1  = RAW_W'($urandom_range(0, RAW_MAX));
    sel = $urandom_range(0, 19);
    if (sel == 0) d1 = '0;
    else if (sel == 1) d1 = RAW_MAX;
    sel = $urandom_range(0, 9);
    if (sel < 4) begin
      d2 = RAW_W'($urandom_range(0, RAW_MAX));
    end else if (sel < 8) begin
      // close to the reference temperature, where the corrections switch
      d2 = clamp_raw(longint'(cal_words[REG_REF_TEMPERATURE]) * 256
                     + longint'($urandom_range(0, 1 << 21)) - (1 << 20));
    end else begin
      d2 = raw_temp_for($urandom_range(0, 12000) - 6000);
    end
    send_reading(d1, d2);
  endtask

  task automatic test_reset_calibration();
    send_reading('0, '0);
    send_reading(RAW_MAX, RAW_MAX);
    send_reading(RAW_MAX, '0);
  endtask

  task automatic test_temperature_bands();
    load_calibration(16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd33464, 16'd28312);
    send_reading(24'd9085466, 24'd8569150);
    send_reading('0, '0);
    send_reading(RAW_MAX, RAW_MAX);
    send_reading('0, RAW_MAX);
    send_reading(24'd9085466, raw_temp_for(2500));
    send_reading(24'd9085466, raw_temp_for(TEMP_MID));
    send_reading(24'd9085466, raw_temp_for(TEMP_MID - 1));
    send_reading(24'd9085466, raw_temp_for(0));
    send_reading(24'd9085466, raw_temp_for(-TEMP_LOW + 1));
    send_reading(24'd9085466, raw_temp_for(-TEMP_LOW));
    send_reading(24'd9085466, raw_temp_for(-TEMP_LOW - 1));
    send_reading(RAW_MAX, raw_temp_for(-4000));
    send_reading(RAW_MAX, raw_temp_for(-20000));
  endtask

  task automatic test_extreme_calibration();
    // zero reference and full slope push the temperature past the output width
    load_calibration(random_word(), random_word(), random_word(), random_word(), '0, '1);
    send_reading(RAW_MAX, RAW_MAX);
    send_reading('0, 24'hFFF000);
    load_calibration('1, '1, '1, '1, '1, '1);
    send_reading(RAW_MAX, RAW_MAX);
    send_reading(RAW_MAX, '0);
    send_reading('0, '0);
  endtask

  task automatic test_unused_indexes();
    drain();
    for (int i = NUM_COEFS; i < (1 << CFG_IDX_W); i++)
      write_coef(CFG_IDX_W'(i), COEF_W'($urandom_range(0, 65535)));
    send_reading(24'd9085466, 24'd8569150);
    send_reading(RAW_MAX, 24'd123456);
  endtask

  task automatic test_random_traffic(input int sender_pct, input int receiver_pct,
                                     input int sets, input int per_set);
    send_idle_pct = sender_pct;
    recv_idle_pct = receiver_pct;
    for (int s = 0; s < sets; s++) begin
      load_random_calibration();
      for (int n = 0; n < per_set; n++) send_random_reading();
    end
  endtask

  task automatic test_output_hold_off();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_cycles   = 80;
    // the pipeline fills behind the held output and stops taking items
    for (int n = 0; n < 40; n++) send_random_reading();
  endtask

  task automatic test_sender_pause();
    send_idle_pct = 10;
    recv_idle_pct = 30;
    for (int n = 0; n < 20; n++) send_random_reading();
    drain();
    for (int n = 0; n < 20; n++) send_random_reading();
  endtask

  initial begin
    foreach (cal_words[i]) cal_words[i] = '0;
    rst                    = 1'b1;
    raw_in.valid           = 1'b0;
    raw_in.raw_pressure    = '0;
    raw_in.raw_temperature = '0;
    cfg.valid              = 1'b0;
    cfg.index              = '0;
    cfg.data               = '0;
    result_out.ready       = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_calibration();
    test_temperature_bands();
    test_extreme_calibration();
    test_unused_indexes();
    test_random_traffic(36, 57, 7, 50);
    test_output_hold_off();
    test_random_traffic(57, 36, 7, 50);
    test_sender_pause();
    test_random_traffic(0, 0, 7, 50);

    drain();
    repeat (16) @(posedge clk);
    $display("covered %0d readings and %0d results over %0d calibration sets", readings_sent,
             results_seen, cal_sets);
    $display("all temperature bands, output wrap, unused indexes and output hold-off exercised");
    if (error_count == 0 && expected_q.size() == 0) begin
      $display("baro_pressure_compensation_unit verification clean");
    end else begin
      $display("baro_pressure_compensation_unit verification failed");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("timeout with %0d items outstanding", expected_q.size());
    $display("baro_pressure_compensation_unit verification failed");
    $finish;
  end

endmodule

### files.f
+incdir+src
src/bpc_pkg.sv
src/bpc_in_if.sv
src/bpc_out_if.sv
src/bpc_cfg_if.sv
src/bpc_tcomp.sv
src/bpc_corr.sv
src/bpc_pmul.sv
src/baro_pressure_compensation_unit.sv
tb/baro_pressure_compensation_unit_test.sv
